/* sv/wft_pkg.sv */
// wire field tokenizer package: phase codes, result codes and shared structs
`timescale 1ns / 1ps
package wft_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_t;

  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_EOB  = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;
  localparam logic [1:0] ERR_WIRE = 2'd3;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
  localparam logic [3:0] FIXED64_BYTES    = 4'd8;
  localparam logic [3:0] FIXED32_BYTES    = 4'd4;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] accumulator;
    logic [3:0]  byte_count;
    logic [31:0] held_field_number;
    logic [2:0]  held_wire_type;
    logic [63:0] payload_remaining;
  } state_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [31:0]        field_number;
    logic [2:0]         wire_code;
    logic [63:0]        value;
    logic signed [63:0] zigzag_value;
    logic [7:0]         payload_byte;
    logic [1:0]         error_code;
    logic               message_end;
  } result_t;

endpackage

/* sv/wft_ifaces.sv */
// request channel interfaces: input byte stream and decoded result stream
`timescale 1ns / 1ps
interface wft_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface wft_token_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [31:0]        field_number;
  logic [2:0]         wire_code;
  logic [63:0]        value;
  logic signed [63:0] zigzag_value;
  logic [7:0]         payload_byte;
  logic [1:0]         error_code;
  logic               message_end;

  modport source (output valid, output result_kind, output field_number, output wire_code,
                  output value, output zigzag_value, output payload_byte,
                  output error_code, output message_end, input ready);
  modport sink (input valid, input result_kind, input field_number, input wire_code,
                input value, input zigzag_value, input payload_byte,
                input error_code, input message_end, output ready);
endinterface

/* sv/wft_step.sv */
// per-byte decode logic: next parser state and the optional result
`timescale 1ns / 1ps
module wft_step
  import wft_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] data_byte,
  input  logic       buffer_last,
  output state_t     nxt,
  output logic       res_valid,
  output result_t    res
);

  logic [6:0]  var_shamt;
  logic [63:0] acc_var;
  logic [63:0] acc_fix;
  logic [3:0]  count_inc;
  logic        var_long;
  logic        var_more;
  logic [2:0]  tag_wt;
  logic [31:0] tag_fn;
  logic [3:0]  fix_need;
  logic [63:0] zz;

  logic        do_fail;
  logic [1:0]  fail_err;
  logic [31:0] fail_fn;
  logic [2:0]  fail_wt;
  logic        do_finish;
  logic [1:0]  fin_kind;
  logic [63:0] fin_val;
  logic [63:0] fin_zz;

  // 7 * count, only used while count is below ten
  assign var_shamt = {cur.byte_count, 3'b000} - {3'b000, cur.byte_count};
  assign acc_var   = cur.accumulator | ({57'd0, data_byte[6:0]} << var_shamt);
  assign acc_fix   = cur.byte_count[3] ? cur.accumulator
                   : cur.accumulator | ({56'd0, data_byte} << {cur.byte_count[2:0], 3'b000});
  assign count_inc = cur.byte_count + 4'd1;
  assign var_long  = cur.byte_count >= VARINT_MAX_BYTES;
  assign var_more  = data_byte[7];
  assign tag_fn    = acc_var[34:3];
  assign tag_wt    = acc_var[2:0];
  assign fix_need  = (cur.held_wire_type == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
  assign zz        = {1'b0, acc_var[63:1]} ^ {64{acc_var[0]}};

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    do_fail   = 1'b0;
    fail_err  = ERR_NONE;
    fail_fn   = cur.held_field_number;
    fail_wt   = cur.held_wire_type;
    do_finish = 1'b0;
    fin_kind  = KIND_SCALAR;
    fin_val   = '0;
    fin_zz    = '0;

    case (cur.phase)
      PH_TAG: begin
        fail_fn = '0;
        fail_wt = '0;
        if (var_long) begin
          do_fail  = 1'b1;
          fail_err = ERR_LONG;
        end else if (var_more) begin
          if (buffer_last) begin
            do_fail  = 1'b1;
            fail_err = ERR_EOB;
          end else begin
            nxt.accumulator = acc_var;
            nxt.byte_count  = count_inc;
          end
        end else begin
          nxt.held_field_number = tag_fn;
          nxt.held_wire_type    = tag_wt;
          nxt.accumulator       = '0;
          nxt.byte_count        = '0;
          fail_fn               = tag_fn;
          fail_wt               = tag_wt;
          case (tag_wt)
            WT_VARINT:               nxt.phase = PH_VARINT;
            WT_FIXED64, WT_FIXED32:  nxt.phase = PH_FIXED;
            WT_LENGTH:               nxt.phase = PH_LENGTH;
            default: begin
              do_fail  = 1'b1;
              fail_err = ERR_WIRE;
            end
          endcase
          if (!do_fail && buffer_last) begin
            do_fail  = 1'b1;
            fail_err = ERR_EOB;
          end
        end
      end

      PH_VARINT: begin
        if (var_long) begin
          do_fail  = 1'b1;
          fail_err = ERR_LONG;
        end else if (var_more) begin
          if (buffer_last) begin
            do_fail  = 1'b1;
            fail_err = ERR_EOB;
          end else begin
            nxt.accumulator = acc_var;
            nxt.byte_count  = count_inc;
          end
        end else begin
          do_finish = 1'b1;
          fin_kind  = KIND_SCALAR;
          fin_val   = acc_var;
          fin_zz    = zz;
        end
      end

      PH_FIXED: begin
        if (count_inc >= fix_need) begin
          do_finish = 1'b1;
          fin_kind  = KIND_SCALAR;
          fin_val   = acc_fix;
          fin_zz    = acc_fix;
        end else if (buffer_last) begin
          do_fail  = 1'b1;
          fail_err = ERR_EOB;
        end else begin
          nxt.accumulator = acc_fix;
          nxt.byte_count  = count_inc;
        end
      end

      PH_LENGTH: begin
        if (var_long) begin
          do_fail  = 1'b1;
          fail_err = ERR_LONG;
        end else if (var_more) begin
          if (buffer_last) begin
            do_fail  = 1'b1;
            fail_err = ERR_EOB;
          end else begin
            nxt.accumulator = acc_var;
            nxt.byte_count  = count_inc;
          end
        end else if (acc_var == '0) begin
          // empty payload closes the field right away
          do_finish = 1'b1;
          fin_kind  = KIND_HEADER;
        end else if (buffer_last) begin
          do_fail  = 1'b1;
          fail_err = ERR_EOB;
        end else begin
          nxt.accumulator       = '0;
          nxt.byte_count        = '0;
          nxt.payload_remaining = acc_var;
          nxt.phase             = PH_PAYLOAD;
          res_valid             = 1'b1;
          res.result_kind       = KIND_HEADER;
          res.field_number      = cur.held_field_number;
          res.wire_code         = cur.held_wire_type;
          res.value             = acc_var;
          res.zigzag_value      = $signed(acc_var);
        end
      end

      PH_PAYLOAD: begin
        if (cur.payload_remaining <= 64'd1) begin
          nxt.payload_remaining = '0;
          nxt.accumulator       = '0;
          nxt.byte_count        = '0;
          nxt.phase             = PH_TAG;
          res_valid             = 1'b1;
          res.result_kind       = KIND_PAYLOAD;
          res.field_number      = cur.held_field_number;
          res.wire_code         = cur.held_wire_type;
          res.payload_byte      = data_byte;
          res.message_end       = buffer_last;
        end else if (buffer_last) begin
          do_fail  = 1'b1;
          fail_err = ERR_EOB;
        end else begin
          nxt.payload_remaining = cur.payload_remaining - 64'd1;
          res_valid             = 1'b1;
          res.result_kind       = KIND_PAYLOAD;
          res.field_number      = cur.held_field_number;
          res.wire_code         = cur.held_wire_type;
          res.payload_byte      = data_byte;
        end
      end

      default: begin
        // drop bytes until the buffer closes
        if (buffer_last) begin
          nxt.accumulator       = '0;
          nxt.byte_count        = '0;
          nxt.payload_remaining = '0;
          nxt.phase             = PH_TAG;
        end
      end
    endcase

    if (do_finish) begin
      nxt.accumulator  = '0;
      nxt.byte_count   = '0;
      nxt.phase        = PH_TAG;
      res_valid        = 1'b1;
      res              = '0;
      res.result_kind  = fin_kind;
      res.field_number = cur.held_field_number;
      res.wire_code    = cur.held_wire_type;
      res.value        = fin_val;
      res.zigzag_value = $signed(fin_zz);
      res.message_end  = buffer_last;
    end

    if (do_fail) begin
      nxt.accumulator       = '0;
      nxt.byte_count        = '0;
      nxt.payload_remaining = '0;
      nxt.phase             = buffer_last ? PH_TAG : PH_DRAIN;
      res_valid             = 1'b1;
      res                   = '0;
      res.result_kind       = KIND_ERROR;
      res.field_number      = fail_fn;
      res.wire_code         = fail_wt;
      res.error_code        = fail_err;
    end
  end

endmodule

/* sv/wft_out_stage.sv */
// result register between the decode logic and the result channel
`timescale 1ns / 1ps
module wft_out_stage
  import wft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        space,
  wft_token_if.source tokens
);

  logic    valid;
  result_t data;

  assign space = !valid || tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (tokens.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign tokens.valid        = valid;
  assign tokens.result_kind  = data.result_kind;
  assign tokens.field_number = data.field_number;
  assign tokens.wire_code    = data.wire_code;
  assign tokens.value        = data.value;
  assign tokens.zigzag_value = data.zigzag_value;
  assign tokens.payload_byte = data.payload_byte;
  assign tokens.error_code   = data.error_code;
  assign tokens.message_end  = data.message_end;

endmodule

/* sv/wire_field_tokenizer.sv */
// wire field tokenizer top level: parser state registers and result register
// a result appears on the result channel in the cycle after its byte is taken
// throughput: one byte per cycle while the result register has space; the parser state is registered per taken byte
// a stalled result register holds off new bytes until it is taken
// reset clears the parser to the tag phase and empties the result register
`timescale 1ns / 1ps
module wire_field_tokenizer
  import wft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wft_stream_if.sink  stream,
  wft_token_if.source tokens
);

  state_t  state;
  state_t  state_next;
  logic    res_valid;
  result_t res;
  logic    space;
  logic    accept;

  assign stream.ready = space;
  assign accept       = stream.valid && space;

  wft_step u_step (
    .cur         (state),
    .data_byte   (stream.data_byte),
    .buffer_last (stream.buffer_last),
    .nxt         (state_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_TAG, default: '0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  wft_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept && res_valid),
    .res    (res),
    .space  (space),
    .tokens (tokens)
  );

endmodule

/* sv/wft_checker.sv */
// port-level checks for the wire field tokenizer and their bind
`timescale 1ns / 1ps
module wft_assertions
  import wft_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               stream_ready,
  input logic               tok_valid,
  input logic               tok_ready,
  input logic [1:0]         result_kind,
  input logic [2:0]         wire_code,
  input logic [63:0]        value,
  input logic signed [63:0] zigzag_value,
  input logic [7:0]         payload_byte,
  input logic [1:0]         error_code,
  input logic               message_end
);

  // an error carries a code and no value
  assert property (@(posedge clk) disable iff (rst)
    tok_valid && result_kind == KIND_ERROR |->
      error_code != ERR_NONE && value == '0 && zigzag_value == '0 && !message_end)
    else $error("error result carries data");

  // only errors carry a code, only payload results carry a byte
  assert property (@(posedge clk) disable iff (rst)
    tok_valid && result_kind != KIND_ERROR |->
      error_code == ERR_NONE && (result_kind == KIND_PAYLOAD || payload_byte == '0))
    else $error("stray error code or payload byte");

  // varint scalars carry the zigzag decode, other scalars the raw bits
  assert property (@(posedge clk) disable iff (rst)
    tok_valid && result_kind == KIND_SCALAR |->
      (wire_code == WT_VARINT &&
       zigzag_value == $signed({1'b0, value[63:1]} ^ {64{value[0]}})) ||
      (wire_code != WT_VARINT && zigzag_value == $signed(value)))
    else $error("zigzag value mismatch");

  // an empty result register never holds off input
  assert property (@(posedge clk) disable iff (rst)
    !tok_valid |-> stream_ready)
    else $error("input stalled with no pending result");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(value) && $stable(result_kind))
    else $error("stalled result changed");

endmodule

bind wire_field_tokenizer wft_assertions u_wft_assertions (
  .clk          (clk),
  .rst          (rst),
  .stream_ready (stream.ready),
  .tok_valid    (tokens.valid),
  .tok_ready    (tokens.ready),
  .result_kind  (tokens.result_kind),
  .wire_code    (tokens.wire_code),
  .value        (tokens.value),
  .zigzag_value (tokens.zigzag_value),
  .payload_byte (tokens.payload_byte),
  .error_code   (tokens.error_code),
  .message_end  (tokens.message_end)
);
